@@ rtl/crpw_pkg.sv @@
// Shared types, constants and helper functions for the clipped rectangle pixel write block.
// Has no dependencies. Every other file of the block refers to it by scoped names.
package crpw_pkg;

   // Largest image dimension accepted. Larger register values are clamped to it.
   localparam int MAX_DIM    = 1024;
   localparam int PIXEL_BITS = 16;
   localparam int BYTE_BITS  = 8;

   // Widths fixed by the interface.
   localparam int CFG_W      = 11;
   localparam int COORD_W    = 16;
   localparam int SIZE_W     = 15;
   localparam int ADDR_W     = 20;
   localparam int REDRAW_W   = 10;
   localparam int CSR_IDX_W  = 2;

   // Derived internal widths.
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int ROW_W      = COORD_W + 1;
   localparam int COL_W      = COORD_W + 1;
   localparam int PROD_W     = IDX_W + DIM_W;
   localparam int SUM_W      = PROD_W + 1;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   localparam logic ACTION_HEADER = 1'b0;
   localparam logic ACTION_PIXEL  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_IS_16  = 2'd2;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(1024);

   // Image geometry as seen by the datapath, already clamped.
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             depth_is_16;
   } cfg_type;

   // One classified pixel, passed from front to back.
   typedef struct packed {
      logic                  keep;
      logic [IDX_W-1:0]      row_index;
      logic [IDX_W-1:0]      col_index;
      logic [PIXEL_BITS-1:0] data;
      logic                  row_redraw;
      logic [REDRAW_W-1:0]   redraw_row_index;
      logic                  transfer_done;
   } work_type;

   // One finished result beat.
   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_W-1:0]     write_address;
      logic [PIXEL_BITS-1:0] write_data;
      logic                  row_redraw;
      logic [REDRAW_W-1:0]   redraw_row_index;
      logic                  transfer_done;
   } result_type;

   // Clamps a raw dimension register to MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
      logic [CFG_W+DIM_W-1:0] wide;
      wide = (CFG_W+DIM_W)'(value);
      if (wide > (CFG_W+DIM_W)'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(wide);
   endfunction

endpackage

@@ rtl/crpw_ifs.sv @@
// Valid/ready channel interfaces for request beats and result beats.
// Depends on crpw_pkg for the field widths.
interface crpw_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic signed [crpw_pkg::COORD_W-1:0]  start_column;
   logic signed [crpw_pkg::COORD_W-1:0]  start_row;
   logic [crpw_pkg::SIZE_W-1:0]          rect_width;
   logic [crpw_pkg::SIZE_W-1:0]          rect_height;
   logic [crpw_pkg::PIXEL_BITS-1:0]      pixel_value;

   modport source (
      output valid, action, start_column, start_row, rect_width, rect_height, pixel_value,
      input  ready
   );
   modport sink (
      input  valid, action, start_column, start_row, rect_width, rect_height, pixel_value,
      output ready
   );
endinterface

interface crpw_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            write_enable;
   logic [crpw_pkg::ADDR_W-1:0]     write_address;
   logic [crpw_pkg::PIXEL_BITS-1:0] write_data;
   logic                            row_redraw;
   logic [crpw_pkg::REDRAW_W-1:0]   redraw_row_index;
   logic                            transfer_done;

   modport source (
      output valid, write_enable, write_address, write_data, row_redraw,
             redraw_row_index, transfer_done,
      input  ready
   );
   modport sink (
      input  valid, write_enable, write_address, write_data, row_redraw,
             redraw_row_index, transfer_done,
      output ready
   );
endinterface

@@ rtl/crpw_front.sv @@
// Front end: accepts request beats, tracks the open rectangle and clips each pixel.
// Depends on crpw_pkg and crpw_req_if; pushes classified pixels into crpw_queue.
module crpw_front (
   input  logic                 clock,
   input  logic                 reset,
   crpw_req_if.sink             req,
   input  crpw_pkg::cfg_type    cfg,
   input  logic                 push_ready,
   output logic                 push_valid,
   output crpw_pkg::work_type   push_data
);

   logic                                active_ff, active_in;
   logic [crpw_pkg::COORD_W-1:0]        origin_ff, origin_in;
   logic [crpw_pkg::SIZE_W-1:0]         line_width_ff, line_width_in;
   logic [crpw_pkg::SIZE_W-1:0]         rows_left_ff, rows_left_in;
   logic [crpw_pkg::ROW_W-1:0]          row_ff, row_in;
   logic [crpw_pkg::SIZE_W-1:0]         offset_ff, offset_in;

   logic                                accept;
   logic                                is_pixel;
   logic [crpw_pkg::COL_W-1:0]          col;
   logic [crpw_pkg::SIZE_W:0]           offset_next;
   logic                                row_ok;
   logic                                keep;
   logic                                last_in_row;
   logic                                last;

   assign req.ready  = push_ready;
   assign accept     = req.valid && req.ready;
   assign is_pixel   = (req.action == crpw_pkg::ACTION_PIXEL);
   assign push_valid = accept && is_pixel && active_ff;

   // Column and row tests are done on sign-extended values, so negative
   // coordinates fail the lower bound through their sign bit.
   assign col = {origin_ff[crpw_pkg::COORD_W-1], origin_ff}
                + crpw_pkg::COL_W'(offset_ff);
   assign offset_next = (crpw_pkg::SIZE_W+1)'(offset_ff) + (crpw_pkg::SIZE_W+1)'(1);
   assign row_ok = !row_ff[crpw_pkg::ROW_W-1]
                   && (row_ff < crpw_pkg::ROW_W'(cfg.height));
   assign keep = row_ok && !col[crpw_pkg::COL_W-1]
                 && (col < crpw_pkg::COL_W'(cfg.width));
   assign last_in_row = offset_next >= (crpw_pkg::SIZE_W+1)'(line_width_ff);
   assign last = last_in_row && (rows_left_ff <= crpw_pkg::SIZE_W'(1));

   always_comb begin
      push_data.keep       = keep;
      push_data.row_index  = row_ff[crpw_pkg::IDX_W-1:0];
      push_data.col_index  = col[crpw_pkg::IDX_W-1:0];
      if (!keep) begin
         push_data.data = '0;
      end else if (cfg.depth_is_16) begin
         push_data.data = req.pixel_value;
      end else begin
         push_data.data = crpw_pkg::PIXEL_BITS'(req.pixel_value >> crpw_pkg::BYTE_BITS);
      end
      push_data.row_redraw       = last_in_row && row_ok;
      push_data.redraw_row_index = (last_in_row && row_ok)
                                   ? row_ff[crpw_pkg::REDRAW_W-1:0] : '0;
      push_data.transfer_done    = last;
   end

   always_comb begin
      active_in     = active_ff;
      origin_in     = origin_ff;
      line_width_in = line_width_ff;
      rows_left_in  = rows_left_ff;
      row_in        = row_ff;
      offset_in     = offset_ff;
      if (accept && !is_pixel) begin
         origin_in     = req.start_column;
         row_in        = {req.start_row[crpw_pkg::COORD_W-1], req.start_row};
         line_width_in = req.rect_width;
         rows_left_in  = req.rect_height;
         offset_in     = '0;
         active_in     = (req.rect_width != '0) && (req.rect_height != '0);
      end else if (push_valid) begin
         if (last_in_row) begin
            offset_in = '0;
            row_in    = row_ff + crpw_pkg::ROW_W'(1);
            if (rows_left_ff != '0) begin
               rows_left_in = rows_left_ff - crpw_pkg::SIZE_W'(1);
            end
            if (last) begin
               active_in = 1'b0;
            end
         end else begin
            offset_in = offset_next[crpw_pkg::SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         origin_ff     <= '0;
         line_width_ff <= '0;
         rows_left_ff  <= '0;
         row_ff        <= '0;
         offset_ff     <= '0;
      end else begin
         active_ff     <= active_in;
         origin_ff     <= origin_in;
         line_width_ff <= line_width_in;
         rows_left_ff  <= rows_left_in;
         row_ff        <= row_in;
         offset_ff     <= offset_in;
      end
   end

endmodule

@@ rtl/crpw_queue.sv @@
// Short first-in first-out queue of classified pixels between front and back.
// Depends on crpw_pkg for the entry type and depth.
module crpw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  crpw_pkg::work_type   push_data,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output crpw_pkg::work_type   head_data
);

   crpw_pkg::work_type                entries_ff [crpw_pkg::QUEUE_DEPTH];
   logic [crpw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [crpw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [crpw_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = count_ff < crpw_pkg::QCNT_W'(crpw_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == crpw_pkg::QPTR_W'(crpw_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + crpw_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == crpw_pkg::QPTR_W'(crpw_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + crpw_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + crpw_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - crpw_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/crpw_back.sv @@
// Back end: forms the frame address of each queued pixel and holds the result beat.
// Depends on crpw_pkg and crpw_rsp_if; pops entries from crpw_queue.
module crpw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [crpw_pkg::DIM_W-1:0] image_width,
   input  logic                       head_valid,
   input  crpw_pkg::work_type         head_data,
   output logic                       pop,
   crpw_rsp_if.source                 rsp
);

   logic                        out_valid_ff, out_valid_in;
   crpw_pkg::result_type        out_ff, out_in;
   logic [crpw_pkg::PROD_W-1:0] product;
   logic [crpw_pkg::SUM_W-1:0]  address_sum;

   // The output register takes a new beat whenever it is empty or its beat
   // is taken in the same cycle.
   assign pop = head_valid && (!out_valid_ff || rsp.ready);

   assign product     = crpw_pkg::PROD_W'(head_data.row_index)
                        * crpw_pkg::PROD_W'(image_width);
   assign address_sum = crpw_pkg::SUM_W'(product) + crpw_pkg::SUM_W'(head_data.col_index);

   always_comb begin
      out_in.write_enable     = head_data.keep;
      out_in.write_address    = head_data.keep ? crpw_pkg::ADDR_W'(address_sum) : '0;
      out_in.write_data       = head_data.data;
      out_in.row_redraw       = head_data.row_redraw;
      out_in.redraw_row_index = head_data.redraw_row_index;
      out_in.transfer_done    = head_data.transfer_done;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.write_enable     = out_ff.write_enable;
   assign rsp.write_address    = out_ff.write_address;
   assign rsp.write_data       = out_ff.write_data;
   assign rsp.row_redraw       = out_ff.row_redraw;
   assign rsp.redraw_row_index = out_ff.redraw_row_index;
   assign rsp.transfer_done    = out_ff.transfer_done;

endmodule

@@ rtl/clipped_rect_pixel_write.sv @@
// Top level of the clipped rectangle pixel write block: configuration registers and wiring.
// Depends on crpw_pkg, crpw_ifs, crpw_front, crpw_queue and crpw_back.
//
// The block turns a stream of beats into frame-memory writes. A header beat opens a
// rectangle with a signed start column and row and an unsigned width and height; the
// pixel beats that follow are taken in row-major order. Every pixel of an open
// rectangle yields exactly one result beat: write_enable tells whether the pixel lands
// inside the image, and if so write_address is row times image width plus column and
// write_data is the pixel, or its high byte when depth_is_16 is clear. The last pixel
// of a row that lies inside the image height raises row_redraw with that row, and the
// last pixel of the rectangle raises transfer_done. Headers, and pixels that arrive
// with no rectangle open, give no result; an empty rectangle opens nothing. The block
// takes one beat every cycle while the queue has room. The front end clips a pixel and
// updates the row and column counters in the cycle that accepts it, and writes it into
// the queue at that edge. The back end, whose single multiplier forms the address,
// then loads it from the queue into the output register once that register is empty
// or its beat is being taken, and the result beat is presented from there. A two-entry
// queue between the two halves holds up to two clipped pixels, so the input keeps
// flowing while the result side stalls until the queue fills. Image width and height
// above the largest supported dimension are taken as that dimension. Configuration
// must be written only while no pixel is in flight.
module clipped_rect_pixel_write (
   input  logic                               clock,
   input  logic                               reset,
   crpw_req_if.sink                           req_chan,
   crpw_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [crpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crpw_pkg::CFG_W-1:0]         csr_write_data
);

   // Raw register values, as written.
   logic [crpw_pkg::CFG_W-1:0] image_width_ff;
   logic [crpw_pkg::CFG_W-1:0] image_height_ff;
   logic                       depth_is_16_ff;

   crpw_pkg::cfg_type          cfg;
   logic                       push_valid;
   logic                       push_ready;
   crpw_pkg::work_type         push_data;
   logic                       pop;
   logic                       head_valid;
   crpw_pkg::work_type         head_data;

   // Writes to an index past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= crpw_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= crpw_pkg::IMAGE_HEIGHT_RESET;
         depth_is_16_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            crpw_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data;
            end
            crpw_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data;
            end
            crpw_pkg::CSR_DEPTH_IS_16: begin
               depth_is_16_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // The datapath only ever sees clamped dimensions.
   always_comb begin
      cfg.width       = crpw_pkg::clamp_dim(image_width_ff);
      cfg.height      = crpw_pkg::clamp_dim(image_height_ff);
      cfg.depth_is_16 = depth_is_16_ff;
   end

   crpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   crpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   crpw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .image_width (cfg.width),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule
